>>> hw/rtl/ssc_pkg.sv
// Package: shared types and constants of the Sturm sequence sign count unit.
`timescale 1ns / 1ps
package ssc_pkg;

	localparam int MAG_W   = 96;
	localparam int MANT_W  = 31;
	localparam int CNT_W   = 13;
	localparam int ONE_Q16 = 65536;

	typedef struct packed {
		logic signed [31:0] diag_value;
		logic signed [31:0] subdiag_value;
		logic signed [31:0] shift_value;
		logic               first_row;
		logic               last_row;
	} row_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] sign_changes;
	} res_item_t;

	typedef enum logic [1:0] {
		SH_0,
		SH_16,
		SH_32
	} mac_sh_t;

	typedef struct packed {
		logic    valid;
		logic    clear;
		logic    neg;
		mac_sh_t sh;
	} mac_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BB,
		ST_Q0,
		ST_Q1,
		ST_P,
		ST_W1,
		ST_ABS,
		ST_LZ1,
		ST_LZ2,
		ST_SH
	} state_t;

endpackage

>>> hw/rtl/ssc_if.sv
// Interfaces: row and result channels of the sign count unit.
`timescale 1ns / 1ps
interface ssc_row_if import ssc_pkg::*; ();
	logic      valid;
	logic      ready;
	row_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ssc_res_if import ssc_pkg::*; ();
	logic      valid;
	logic      ready;
	res_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/sturm_sequence_sign_count_unit.sv
// Top level: Sturm sequence sign count over the rows of a tridiagonal matrix.
//
// channel  dir  payload                                               role
// row      in   diag_value, subdiag_value, shift_value, first/last   one matrix row
// result   out  sign_changes                                          count after last row
//
// Rows are taken only while idle. A first row skips the multiplier; for any other row
// the shared 32x32 multiplier forms b*b, two halves of b*b*y and d*x in turn,
// then a two-step leading-one search and one shift normalize the minors.
// A row marked last holds in the final step while the result register is full and not being read.
// Reset sets x to zero, y to one and the count to zero.
`timescale 1ns / 1ps
module sturm_sequence_sign_count_unit import ssc_pkg::*; #(
	parameter int MAX_ROWS = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	ssc_row_if.sink        row,
	ssc_res_if.source      result
);

	localparam int COUNT_CAP = (MAX_ROWS < 8191) ? MAX_ROWS : 8191;

	state_t st_q, st_d;

	logic [31:0]       dm_q, bm_q;
	logic              dneg_q, last_q;
	logic [30:0]       bbhi_q;
	logic [MANT_W-1:0] xm_q, ym_q, om_q;
	logic              xneg_q, yneg_q, oneg_q, su_q;
	logic [MAG_W-1:0]  um_q;
	logic [2:0]        chunk_q;
	logic              nz_q;
	logic [6:0]        len_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              res_valid_q;
	logic [CNT_W-1:0]  res_q;

	mac_op_t                 op;
	logic [31:0]             mac_a, mac_b;
	logic [63:0]             prod;
	logic signed [MAG_W-1:0] acc;
	logic [63:0]             bbv;

	logic signed [32:0] d_in;
	logic               dneg_in;
	logic [31:0]        dmag_in, bmag_in;
	logic [MAG_W-1:0]   orv;
	logic [2:0]         chunk_d;
	logic [15:0]        word;
	logic [3:0]         pos_d;
	logic               out_free;

	ssc_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.a      (mac_a),
		.b      (mac_b),
		.prod   (prod),
		.acc    (acc)
	);

	function automatic logic [MANT_W-1:0] norm_mant(input logic [MAG_W-1:0] v,
		input logic [6:0] len);
		logic [MAG_W-1:0]  r;
		logic [MANT_W-1:0] res;
		r   = '0;
		res = '0;
		if (len > 7'd31) begin
			r   = v >> (len - 7'd31);
			res = r[MANT_W-1:0];
			if (res == '0 && v != '0) begin
				res = MANT_W'(1);
			end
		end else if (len != 7'd0) begin
			r   = v << (7'd31 - len);
			res = r[MANT_W-1:0];
		end
		return res;
	endfunction

	assign d_in    = {row.data.diag_value[31], row.data.diag_value}
		- {row.data.shift_value[31], row.data.shift_value};
	assign dneg_in = d_in[32];
	assign dmag_in = dneg_in ? 32'(-d_in) : d_in[31:0];
	assign bmag_in = row.data.subdiag_value[31] ? 32'(-row.data.subdiag_value)
		: 32'(row.data.subdiag_value);

	assign bbv      = (prod == '0) ? 64'd1 : prod;
	assign orv      = um_q | MAG_W'(om_q);
	assign word     = orv[{chunk_q, 4'b0000} +: 16];
	assign out_free = !res_valid_q || result.ready;

	always_comb begin
		chunk_d = '0;
		for (int i = 0; i < MAG_W / 16; i++) begin
			if (orv[i*16 +: 16] != '0) begin
				chunk_d = 3'(i);
			end
		end
		pos_d = '0;
		for (int j = 0; j < 16; j++) begin
			if (word[j]) begin
				pos_d = 4'(j);
			end
		end
	end

	always_comb begin
		st_d  = st_q;
		op    = '0;
		mac_a = bm_q;
		mac_b = bm_q;
		case (st_q)
			ST_IDLE: begin
				if (row.valid) begin
					st_d = row.data.first_row ? ST_LZ1 : ST_BB;
				end
			end
			ST_BB: begin
				st_d = ST_Q0;
			end
			ST_Q0: begin
				mac_a = bbv[31:0];
				mac_b = 32'(ym_q);
				op    = '{valid: 1'b1, clear: 1'b1, neg: !yneg_q, sh: SH_0};
				st_d  = ST_Q1;
			end
			ST_Q1: begin
				mac_a = 32'(bbhi_q);
				mac_b = 32'(ym_q);
				op    = '{valid: 1'b1, clear: 1'b0, neg: !yneg_q, sh: SH_32};
				st_d  = ST_P;
			end
			ST_P: begin
				mac_a = dm_q;
				mac_b = 32'(xm_q);
				op    = '{valid: 1'b1, clear: 1'b0, neg: dneg_q ^ xneg_q, sh: SH_16};
				st_d  = ST_W1;
			end
			ST_W1:  st_d = ST_ABS;
			ST_ABS: st_d = ST_LZ1;
			ST_LZ1: st_d = ST_LZ2;
			ST_LZ2: st_d = ST_SH;
			ST_SH: begin
				if (out_free || !last_q) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xm_q        <= '0;
			xneg_q      <= 1'b0;
			ym_q        <= MANT_W'(ONE_Q16);
			yneg_q      <= 1'b0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (row.valid && row.data.first_row) begin
						cnt_q <= CNT_W'(dneg_in);
					end
				end
				ST_ABS: begin
					if (acc != '0 && xm_q != '0 && acc[MAG_W-1] != xneg_q
						&& cnt_q < CNT_W'(COUNT_CAP)) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SH: begin
					if (out_free || !last_q) begin
						xm_q   <= norm_mant(um_q, len_q);
						xneg_q <= su_q;
						ym_q   <= norm_mant(MAG_W'(om_q), len_q);
						yneg_q <= oneg_q;
						if (last_q) begin
							res_valid_q <= 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (row.valid) begin
					last_q <= row.data.last_row;
					dm_q   <= dmag_in;
					dneg_q <= dneg_in;
					bm_q   <= bmag_in;
					um_q   <= MAG_W'(dmag_in);
					su_q   <= dneg_in;
					om_q   <= MANT_W'(ONE_Q16);
					oneg_q <= 1'b0;
				end
			end
			ST_Q0: bbhi_q <= bbv[62:32];
			ST_ABS: begin
				su_q   <= acc[MAG_W-1];
				um_q   <= acc[MAG_W-1] ? MAG_W'(-acc) : MAG_W'(acc);
				om_q   <= xm_q;
				oneg_q <= xneg_q;
			end
			ST_LZ1: begin
				chunk_q <= chunk_d;
				nz_q    <= orv != '0;
			end
			ST_LZ2: begin
				len_q <= nz_q ? (7'({chunk_q, 4'b0000}) + 7'(pos_d) + 7'd1) : 7'd0;
			end
			ST_SH: begin
				if (out_free && last_q) begin
					res_q <= cnt_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign row.ready                = (st_q == ST_IDLE);
	assign result.valid             = res_valid_q;
	assign result.data.sign_changes = res_q;

`ifndef ASSERT_OFF
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(COUNT_CAP))
		else $error("sign count above cap");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		row.valid && row.ready |=> !row.ready)
		else $error("row taken while busy");
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(st_q == ST_SH) && $past(last_q))
		else $error("result without last row");
	a_x_sign: assert property (@(posedge clk) disable iff (!arst_n)
		xneg_q |-> xm_q != '0)
		else $error("negative zero minor");
`endif

endmodule

>>> hw/rtl/ssc_mac.sv
// Shared 32x32 multiplier with registered product and signed shifted accumulator.
`timescale 1ns / 1ps
module ssc_mac import ssc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mac_op_t                 op,
	input  logic [31:0]             a,
	input  logic [31:0]             b,
	output logic [63:0]             prod,
	output logic signed [MAG_W-1:0] acc
);

	logic [63:0]             prod_s1;
	mac_op_t                 op_s1;
	logic signed [MAG_W-1:0] acc_q;
	logic [MAG_W-1:0]        term;
	logic signed [MAG_W-1:0] sterm;

	always_comb begin
		case (op_s1.sh)
			SH_0:    term = MAG_W'(prod_s1);
			SH_16:   term = MAG_W'(prod_s1) << 16;
			SH_32:   term = MAG_W'(prod_s1) << 32;
			default: term = '0;
		endcase
		sterm = op_s1.neg ? -$signed(term) : $signed(term);
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 64'(a) * 64'(b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
		end else begin
			op_s1 <= op;
		end
	end

	always_ff @(posedge clk) begin
		if (op_s1.valid) begin
			acc_q <= (op_s1.clear ? '0 : acc_q) + sterm;
		end
	end

	assign prod = prod_s1;
	assign acc  = acc_q;

endmodule
